/* design/sgr_dec_pkg.sv */
package sgr_dec_pkg;

  typedef struct packed {
    logic [15:0] param_value;
    logic        param_absent;
    logic        is_sub;
    logic        last_param;
  } sgr_in_t;

  typedef struct packed {
    logic [7:0]  attr_bits;
    logic [1:0]  fg_kind;
    logic [23:0] fg_value;
    logic [1:0]  bg_kind;
    logic [23:0] bg_value;
  } sgr_out_t;

  typedef struct packed {
    logic [2:0]      phase;
    logic [1:0]      target;
    logic [8:0]      mode;
    logic [2:0][8:0] win;
    logic [1:0]      count;
  } sgr_ctx_t;

  typedef struct packed {
    sgr_out_t style;
    sgr_ctx_t ctx;
  } sgr_state_t;

  localparam logic [2:0] PH_CODE   = 3'd0;
  localparam logic [2:0] PH_GROUP  = 3'd1;
  localparam logic [2:0] PH_UL_SUB = 3'd2;
  localparam logic [2:0] PH_MODE   = 3'd3;
  localparam logic [2:0] PH_COLON  = 3'd4;
  localparam logic [2:0] PH_FLAT   = 3'd5;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_FG   = 2'd1;
  localparam logic [1:0] TGT_BG   = 2'd2;

  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_RGB     = 2'd2;

  localparam logic [8:0] BAD_BYTE  = 9'h100;
  localparam logic [8:0] MODE_IDX  = 9'd5;
  localparam logic [8:0] MODE_RGB  = 9'd2;

  localparam int ATTR_BOLD    = 0;
  localparam int ATTR_DIM     = 1;
  localparam int ATTR_ITALIC  = 2;
  localparam int ATTR_ULINE   = 3;
  localparam int ATTR_BLINK   = 4;
  localparam int ATTR_REVERSE = 5;
  localparam int ATTR_HIDDEN  = 6;
  localparam int ATTR_STRIKE  = 7;

  localparam logic [15:0] SGR_RESET        = 16'd0;
  localparam logic [15:0] SGR_BOLD         = 16'd1;
  localparam logic [15:0] SGR_DIM          = 16'd2;
  localparam logic [15:0] SGR_ITALIC       = 16'd3;
  localparam logic [15:0] SGR_ULINE        = 16'd4;
  localparam logic [15:0] SGR_BLINK_SLOW   = 16'd5;
  localparam logic [15:0] SGR_BLINK_FAST   = 16'd6;
  localparam logic [15:0] SGR_REVERSE      = 16'd7;
  localparam logic [15:0] SGR_HIDDEN       = 16'd8;
  localparam logic [15:0] SGR_STRIKE       = 16'd9;
  localparam logic [15:0] SGR_DBL_ULINE    = 16'd21;
  localparam logic [15:0] SGR_NO_BOLD_DIM  = 16'd22;
  localparam logic [15:0] SGR_NO_ITALIC    = 16'd23;
  localparam logic [15:0] SGR_NO_ULINE     = 16'd24;
  localparam logic [15:0] SGR_NO_BLINK     = 16'd25;
  localparam logic [15:0] SGR_NO_REVERSE   = 16'd27;
  localparam logic [15:0] SGR_NO_HIDDEN    = 16'd28;
  localparam logic [15:0] SGR_NO_STRIKE    = 16'd29;
  localparam logic [15:0] SGR_FG_BASE      = 16'd30;
  localparam logic [15:0] SGR_FG_LAST      = 16'd37;
  localparam logic [15:0] SGR_FG_EXT       = 16'd38;
  localparam logic [15:0] SGR_FG_DEFAULT   = 16'd39;
  localparam logic [15:0] SGR_BG_BASE      = 16'd40;
  localparam logic [15:0] SGR_BG_LAST      = 16'd47;
  localparam logic [15:0] SGR_BG_EXT       = 16'd48;
  localparam logic [15:0] SGR_BG_DEFAULT   = 16'd49;
  localparam logic [15:0] SGR_UL_EXT       = 16'd58;
  localparam logic [15:0] SGR_FG_BRIGHT    = 16'd90;
  localparam logic [15:0] SGR_FG_BRIGHT_HI = 16'd97;
  localparam logic [15:0] SGR_BG_BRIGHT    = 16'd100;
  localparam logic [15:0] SGR_BG_BRIGHT_HI = 16'd107;
  localparam logic [15:0] BRIGHT_OFFSET    = 16'd8;
  localparam logic [15:0] BYTE_MAX         = 16'd255;

endpackage

/* design/sgr_dec_decode.sv */
module sgr_dec_decode (
  input  sgr_dec_pkg::sgr_state_t state_i,
  input  sgr_dec_pkg::sgr_in_t    item_i,
  output sgr_dec_pkg::sgr_state_t state_o
);
  import sgr_dec_pkg::*;

  function automatic sgr_state_t commit_colour(input sgr_state_t s, input logic [1:0] nargs);
    sgr_state_t r;
    logic [1:0]  kind;
    logic [23:0] val;
    logic        ok;
    r    = s;
    kind = KIND_DEFAULT;
    val  = '0;
    ok   = 1'b0;
    if (s.ctx.mode == MODE_IDX) begin
      ok   = (nargs != 2'd0) && ((s.ctx.win[0] & BAD_BYTE) == 9'd0);
      kind = KIND_PALETTE;
      val  = {16'd0, s.ctx.win[0][7:0]};
    end else if (s.ctx.mode == MODE_RGB) begin
      ok   = (nargs == 2'd3) &&
             (((s.ctx.win[0] | s.ctx.win[1] | s.ctx.win[2]) & BAD_BYTE) == 9'd0);
      kind = KIND_RGB;
      val  = {s.ctx.win[2][7:0], s.ctx.win[1][7:0], s.ctx.win[0][7:0]};
    end
    if (ok && s.ctx.target == TGT_FG) begin
      r.style.fg_kind  = kind;
      r.style.fg_value = val;
    end else if (ok && s.ctx.target == TGT_BG) begin
      r.style.bg_kind  = kind;
      r.style.bg_value = val;
    end
    return r;
  endfunction

  function automatic sgr_state_t start_code(input sgr_state_t s, input logic [15:0] v,
                                            input logic absent);
    sgr_state_t  r;
    logic [15:0] code;
    r    = s;
    code = absent ? SGR_RESET : v;
    if (code == SGR_FG_EXT || code == SGR_BG_EXT || code == SGR_UL_EXT) begin
      r.ctx.phase  = PH_MODE;
      r.ctx.target = (code == SGR_FG_EXT) ? TGT_FG :
                     (code == SGR_BG_EXT) ? TGT_BG : TGT_NONE;
    end else begin
      r.ctx.phase  = PH_GROUP;
      r.ctx.target = TGT_NONE;
      if (code == SGR_RESET) begin
        r.style = '0;
      end else if (code == SGR_BOLD) begin
        r.style.attr_bits[ATTR_BOLD] = 1'b1;
      end else if (code == SGR_DIM) begin
        r.style.attr_bits[ATTR_DIM] = 1'b1;
      end else if (code == SGR_ITALIC) begin
        r.style.attr_bits[ATTR_ITALIC] = 1'b1;
      end else if (code == SGR_ULINE) begin
        r.style.attr_bits[ATTR_ULINE] = 1'b1;
        r.ctx.phase = PH_UL_SUB;
      end else if (code == SGR_BLINK_SLOW || code == SGR_BLINK_FAST) begin
        r.style.attr_bits[ATTR_BLINK] = 1'b1;
      end else if (code == SGR_REVERSE) begin
        r.style.attr_bits[ATTR_REVERSE] = 1'b1;
      end else if (code == SGR_HIDDEN) begin
        r.style.attr_bits[ATTR_HIDDEN] = 1'b1;
      end else if (code == SGR_STRIKE) begin
        r.style.attr_bits[ATTR_STRIKE] = 1'b1;
      end else if (code == SGR_DBL_ULINE) begin
        r.style.attr_bits[ATTR_ULINE] = 1'b1;
      end else if (code == SGR_NO_BOLD_DIM) begin
        r.style.attr_bits[ATTR_BOLD] = 1'b0;
        r.style.attr_bits[ATTR_DIM]  = 1'b0;
      end else if (code == SGR_NO_ITALIC) begin
        r.style.attr_bits[ATTR_ITALIC] = 1'b0;
      end else if (code == SGR_NO_ULINE) begin
        r.style.attr_bits[ATTR_ULINE] = 1'b0;
      end else if (code == SGR_NO_BLINK) begin
        r.style.attr_bits[ATTR_BLINK] = 1'b0;
      end else if (code == SGR_NO_REVERSE) begin
        r.style.attr_bits[ATTR_REVERSE] = 1'b0;
      end else if (code == SGR_NO_HIDDEN) begin
        r.style.attr_bits[ATTR_HIDDEN] = 1'b0;
      end else if (code == SGR_NO_STRIKE) begin
        r.style.attr_bits[ATTR_STRIKE] = 1'b0;
      end else if (code == SGR_FG_DEFAULT) begin
        r.style.fg_kind  = KIND_DEFAULT;
        r.style.fg_value = '0;
      end else if (code == SGR_BG_DEFAULT) begin
        r.style.bg_kind  = KIND_DEFAULT;
        r.style.bg_value = '0;
      end else if (code >= SGR_FG_BASE && code <= SGR_FG_LAST) begin
        r.style.fg_kind  = KIND_PALETTE;
        r.style.fg_value = 24'(code - SGR_FG_BASE);
      end else if (code >= SGR_BG_BASE && code <= SGR_BG_LAST) begin
        r.style.bg_kind  = KIND_PALETTE;
        r.style.bg_value = 24'(code - SGR_BG_BASE);
      end else if (code >= SGR_FG_BRIGHT && code <= SGR_FG_BRIGHT_HI) begin
        r.style.fg_kind  = KIND_PALETTE;
        r.style.fg_value = 24'(code - SGR_FG_BRIGHT + BRIGHT_OFFSET);
      end else if (code >= SGR_BG_BRIGHT && code <= SGR_BG_BRIGHT_HI) begin
        r.style.bg_kind  = KIND_PALETTE;
        r.style.bg_value = 24'(code - SGR_BG_BRIGHT + BRIGHT_OFFSET);
      end
    end
    return r;
  endfunction

  logic [8:0] enc;
  sgr_state_t s;
  logic [1:0] cnt_dec;

  assign enc = (item_i.param_absent || item_i.param_value > BYTE_MAX) ? BAD_BYTE
             : {1'b0, item_i.param_value[7:0]};
  assign cnt_dec = (state_i.ctx.count != 2'd0) ? state_i.ctx.count - 2'd1 : 2'd0;

  always_comb begin
    s = state_i;
    unique case (state_i.ctx.phase)
      PH_COLON: begin
        if (item_i.is_sub) begin
          s.ctx.win   = {state_i.ctx.win[1], state_i.ctx.win[0], enc};
          s.ctx.count = (state_i.ctx.count != 2'd3) ? state_i.ctx.count + 2'd1 : 2'd3;
        end else begin
          s = commit_colour(s, state_i.ctx.count);
          s = start_code(s, item_i.param_value, item_i.param_absent);
        end
      end
      PH_FLAT: begin
        s.ctx.win   = {state_i.ctx.win[1], state_i.ctx.win[0], enc};
        s.ctx.count = cnt_dec;
        if (cnt_dec == 2'd0) begin
          s = commit_colour(s, (state_i.ctx.mode == MODE_IDX) ? 2'd1 : 2'd3);
          s.ctx.phase = PH_CODE;
        end
      end
      PH_MODE: begin
        s.ctx.mode  = enc;
        s.ctx.win   = '0;
        s.ctx.count = 2'd0;
        if (item_i.is_sub) begin
          s.ctx.phase = PH_COLON;
        end else if (enc == MODE_IDX) begin
          s.ctx.count = 2'd1;
          s.ctx.phase = PH_FLAT;
        end else if (enc == MODE_RGB) begin
          s.ctx.count = 2'd3;
          s.ctx.phase = PH_FLAT;
        end else begin
          s.ctx.phase = PH_CODE;
        end
      end
      PH_UL_SUB: begin
        if (item_i.is_sub) begin
          if (!item_i.param_absent && item_i.param_value == 16'd0) begin
            s.style.attr_bits[ATTR_ULINE] = 1'b0;
          end
          s.ctx.phase = PH_GROUP;
        end else begin
          s = start_code(s, item_i.param_value, item_i.param_absent);
        end
      end
      PH_GROUP: begin
        if (!item_i.is_sub) begin
          s = start_code(s, item_i.param_value, item_i.param_absent);
        end
      end
      default: begin
        s = start_code(s, item_i.param_value, item_i.param_absent);
      end
    endcase

    if (item_i.last_param) begin
      if (s.ctx.phase == PH_COLON) begin
        s = commit_colour(s, s.ctx.count);
      end
      s.ctx = '0;
    end
    state_o = s;
  end

endmodule

/* design/sgr_attribute_decoder_unit.sv */
// Each beat is registered at the input; the style is registered at the output when the last parameter fires.
// Throughput: one parameter per cycle, but the last parameter is held while a finished style waits at the output.
// A parameter without the last flag never waits for the output side.
// Reset clears the style to plain text with default colours, returns the parser
// to expecting a code and drops both valid flags.
module sgr_attribute_decoder_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sgr_dec_pkg::sgr_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sgr_dec_pkg::sgr_out_t out_data_o
);
  import sgr_dec_pkg::*;

  logic       in_valid_q;
  sgr_in_t    in_data_q;
  sgr_state_t state_q;
  sgr_state_t state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  sgr_out_t   out_data_q;
  logic       out_free;
  logic       fire;

  sgr_dec_decode u_decode (
    .state_i (state_q),
    .item_i  (in_data_q),
    .state_o (state_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && (!in_data_q.last_param || out_free);
  assign in_ready_o = !in_valid_q || fire;

  always_comb begin
    if (fire && in_data_q.last_param) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (fire && in_data_q.last_param) begin
      out_data_q <= state_d.style;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
